[rtl/core/casf_pkg.sv]
// Types, constants and the speckle test shared by the azimuth speckle filter.
`default_nettype none
package casf_pkg;

	localparam int HEIGHT_W    = 8;
	localparam int INDEX_W     = 10;
	localparam int MAX_RESULTS = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int PUSH_CNT_W  = $clog2(MAX_RESULTS + 1);
	localparam int INDEX_MAX   = (1 << INDEX_W) - 1;

	typedef struct packed {
		logic [HEIGHT_W-1:0] height_in;
		logic                ring_end_in;
	} casf_in_t;

	typedef struct packed {
		logic [INDEX_W-1:0]  ray_index;
		logic [HEIGHT_W-1:0] height_out;
		logic                was_cleared;
		logic                ring_done;
	} casf_result_t;

	// Results produced by one request, item[0] goes out first.
	typedef struct packed {
		logic [PUSH_CNT_W-1:0]                count;
		casf_result_t [MAX_RESULTS-1:0]       item;
	} casf_push_t;

	function automatic casf_result_t make_result(
		input logic [INDEX_W-1:0]  index,
		input logic [HEIGHT_W-1:0] prev,
		input logic [HEIGHT_W-1:0] cur,
		input logic [HEIGHT_W-1:0] next,
		input logic                done
	);
		logic [HEIGHT_W:0] sum;
		logic              isolated;
		logic              too_high;
		casf_result_t      res;
		sum      = {1'b0, prev} + {1'b0, next};
		isolated = ((prev | next) == '0) && (cur != '0);
		too_high = {1'b0, cur} > sum;
		res.ray_index   = index;
		res.was_cleared = isolated || too_high;
		res.height_out  = res.was_cleared ? '0 : cur;
		res.ring_done   = done;
		return res;
	endfunction

endpackage
`default_nettype wire

[rtl/core/circular_azimuth_speckle_filter.sv]
// Circular azimuth speckle filter: top level with the ray window and ring state.
//
// Request channel (req_*): one height code per ray of a range bin, rays in ring
// order, ring_end_in set on the last ray of the ring. A request is taken at a
// clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): filtered heights with their ray index. A middle ray
// comes out one request late; the last request of a ring yields up to three
// responses: the ray before it, the last ray, then ray 0 with ring_done set.
// Latency: with an empty queue, a response shows on rsp_valid the cycle after
// the request that causes it is taken. Throughput: one request per cycle while
// req_stall is low; the queue (four entries) drains one response per cycle
// while rsp_stall is low, so a ring end with three responses raises req_stall.
// req_stall rises whenever fewer than three queue entries are free, so a
// stalled receiver stops the request side once two responses wait, with at
// most four held. Rings longer than MAX_RAYS hold the ray counter at its cap.
// Reset clears the ring state and empties the queue; the first request after
// reset starts a new ring.
`default_nettype none
module circular_azimuth_speckle_filter #(
	parameter int MAX_RAYS = 1024
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	output logic                   req_stall,
	input  casf_pkg::casf_in_t     req_data,
	output logic                   rsp_valid,
	input  wire                    rsp_stall,
	output casf_pkg::casf_result_t rsp_data
);
	import casf_pkg::*;

	localparam int RAY_CAP_INT = (MAX_RAYS - 1 < INDEX_MAX) ? MAX_RAYS - 1 : INDEX_MAX;
	localparam logic [INDEX_W-1:0] RayCap = INDEX_W'(RAY_CAP_INT);

	logic [HEIGHT_W-1:0] first_q;
	logic [HEIGHT_W-1:0] second_q;
	logic [HEIGHT_W-1:0] older_q;
	logic [HEIGHT_W-1:0] newer_q;
	logic [INDEX_W-1:0]  ray_cnt_q;

	logic                room;
	logic                accept;
	logic [HEIGHT_W-1:0] h;
	logic [HEIGHT_W-1:0] first_eff;
	logic [HEIGHT_W-1:0] second_eff;
	logic                n_zero;
	logic                n_one;
	casf_push_t          push;

	assign req_stall  = !room;
	assign accept     = req_valid && room;
	assign h          = req_data.height_in;
	assign n_zero     = ray_cnt_q == '0;
	assign n_one      = ray_cnt_q == INDEX_W'(1);
	assign first_eff  = n_zero ? h : first_q;
	assign second_eff = n_one ? h : second_q;

	always_comb begin
		push.count = '0;
		push.item  = '0;
		if (accept) begin
			if (!n_zero && !n_one) begin
				push.item[0] = make_result(ray_cnt_q - INDEX_W'(1), older_q, newer_q, h, 1'b0);
				push.count   = PUSH_CNT_W'(1);
			end
			if (req_data.ring_end_in) begin
				if (n_zero) begin
					push.item[0] = make_result('0, h, h, h, 1'b1);
					push.count   = PUSH_CNT_W'(1);
				end else if (n_one) begin
					push.item[0] = make_result(ray_cnt_q, newer_q, h, first_eff, 1'b0);
					push.item[1] = make_result('0, h, first_eff, second_eff, 1'b1);
					push.count   = PUSH_CNT_W'(2);
				end else begin
					push.item[1] = make_result(ray_cnt_q, newer_q, h, first_eff, 1'b0);
					push.item[2] = make_result('0, h, first_eff, second_eff, 1'b1);
					push.count   = PUSH_CNT_W'(3);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= '0;
			second_q  <= '0;
			older_q   <= '0;
			newer_q   <= '0;
			ray_cnt_q <= '0;
		end else if (accept) begin
			if (req_data.ring_end_in) begin
				// close the ring: drop all history
				first_q   <= '0;
				second_q  <= '0;
				older_q   <= '0;
				newer_q   <= '0;
				ray_cnt_q <= '0;
			end else begin
				first_q   <= first_eff;
				second_q  <= second_eff;
				older_q   <= newer_q;
				newer_q   <= h;
				ray_cnt_q <= (ray_cnt_q < RayCap) ? ray_cnt_q + INDEX_W'(1) : RayCap;
			end
		end
	end

	casf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

endmodule
`default_nettype wire

[rtl/core/casf_queue.sv]
// Result queue: per cycle takes up to three results, pops one unless stalled.
`default_nettype none
module casf_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  casf_pkg::casf_push_t push,
	output logic                 room,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output casf_pkg::casf_result_t rsp_data
);
	import casf_pkg::*;

	casf_result_t [QUEUE_DEPTH-1:0] entry_q;
	casf_result_t [QUEUE_DEPTH-1:0] entry_d;
	logic [QCNT_W-1:0]              count_q;
	logic [QCNT_W-1:0]              count_d;
	logic [QCNT_W-1:0]              base;
	logic [QCNT_W-1:0]              pos;
	logic [QCNT_W-1:0]              slot;
	logic                           pop;

	assign rsp_valid = count_q != '0;
	assign rsp_data  = entry_q[0];
	assign pop       = rsp_valid && !rsp_stall;
	// Room for a full burst of results, decided on the registered count only.
	assign room      = count_q <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);

	always_comb begin
		base    = count_q - QCNT_W'(pop);
		count_d = base + QCNT_W'(push.count);
		pos     = '0;
		slot    = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			pos = QCNT_W'(i);
			if (pos < base) begin
				// advance the surviving entries toward the head
				entry_d[i] = pop ? entry_q[(i + 1) % QUEUE_DEPTH] : entry_q[i];
			end else begin
				slot = pos - base;
				if (slot < QCNT_W'(push.count))
					entry_d[i] = push.item[slot[PUSH_CNT_W-1:0]];
				else
					entry_d[i] = entry_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule
`default_nettype wire

[rtl/core/casf_checker.sv]
// Port-level checks for the azimuth speckle filter, bound to its top level.
`default_nettype none
module casf_checker (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    req_valid,
	input wire                    req_stall,
	input casf_pkg::casf_in_t     req_data,
	input wire                    rsp_valid,
	input wire                    rsp_stall,
	input casf_pkg::casf_result_t rsp_data
);
	import casf_pkg::*;

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response changed");

	// ring close always reports ray 0
	a_done_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.ring_done |-> rsp_data.ray_index == '0)
		else $error("ring_done on nonzero ray index");

	// every other response lies past ray 0
	a_mid_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.ring_done |-> rsp_data.ray_index != '0)
		else $error("ray 0 reported before ring close");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.was_cleared |-> rsp_data.height_out == '0)
		else $error("cleared response carries a height");

	// an accepted ring close always leaves a response waiting
	a_ring_end_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_data.ring_end_in |=> rsp_valid)
		else $error("ring close left no response");

endmodule

bind circular_azimuth_speckle_filter casf_checker u_casf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req_data (req_data),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp_data (rsp_data)
);
`default_nettype wire
